FILE: rtl/artfh_pkg.sv
// Package for the ray/triangle first-hit block: field widths, register
// indexes, sequencer states and the triangle beat layout. No dependencies.
package artfh_pkg;
	localparam int unsigned MaxCandidates = 256;
	localparam int unsigned PosW = $clog2(MaxCandidates);
	localparam int unsigned DivSteps = 64;

	typedef enum logic [2:0] {
		REG_QUERY_X = 3'd0,
		REG_QUERY_Z = 3'd1,
		REG_SEG_Y_LOW = 3'd2,
		REG_SEG_Y_HIGH = 3'd3,
		REG_PAR_TOL = 3'd4,
		REG_AREA_TOL = 3'd5
	} reg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_NUM0,
		ST_NUM1,
		ST_NUM2,
		ST_DIV,
		ST_RANGE,
		ST_AREA,
		ST_DECIDE,
		ST_OUT
	} state_t;

	// The first field of the beat sits in the lowest bits, so it is declared last.
	typedef struct packed {
		logic [31:0] normal_y;
		logic [31:0] vert2_x;
		logic [31:0] vert2_z;
		logic [31:0] vert1_x;
		logic [31:0] vert1_z;
		logic [31:0] vert0_x;
		logic [31:0] vert0_z;
		logic [31:0] plane_d;
		logic [31:0] plane_c;
		logic [31:0] plane_b;
		logic [31:0] plane_a;
	} tri_t;
endpackage

FILE: rtl/axis_ray_triangle_first_hit_top.sv
// Top level of the ray/triangle first-hit block.
// Depends on artfh_pkg.
//
// Software writes the query line, the y segment and two tolerances through
// the write port (cfg_we, cfg_index, cfg_data) while the block is idle.
// Candidate triangles then arrive one beat at a time on the s_axis side;
// s_axis_tlast marks the final candidate of a list. For each list the block
// sends at most one beat on m_axis: the first triangle crossed (hit set,
// y and list position), or a miss beat on the last candidate.
// A triangle that reaches the area test passes these steps: ST_NUM0 to
// ST_NUM2 form the numerator with the shared 34x34 multiplier, a restoring
// divider in ST_DIV takes one quotient bit a cycle for a 64-bit quotient,
// ST_RANGE checks the segment, ST_AREA forms the three areas with six
// multiplies, and ST_DECIDE decides. Parallel planes and candidates after
// a hit skip straight from idle to ST_DECIDE. The block
// holds s_axis_tready low while a triangle is at work. The result sits in an
// output register until the receiver takes it; the next beat is accepted
// only after that. Reset clears the list state and the configuration
// registers to zero.
module axis_ray_triangle_first_hit_top (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [2:0]   cfg_index,
	input  logic [31:0]  cfg_data,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// plane_a, plane_b, plane_c, plane_d, vert0_z, vert0_x, vert1_z, vert1_x,
	// vert2_z, vert2_x, normal_y
	input  logic [351:0] s_axis_tdata,
	input  logic         s_axis_tlast,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// hit, intersect_y, hit_position (48 bits, zero filled)
	output logic [47:0]  m_axis_tdata
);
	artfh_pkg::state_t state_q, state_nxt;
	logic signed [31:0] qx_q, qz_q, ylo_q, yhi_q;
	logic [15:0] ptol_q, atol_q;
	artfh_pkg::tri_t tri_q;
	logic last_q, found_q;
	logic [artfh_pkg::PosW-1:0] count_q;
	logic signed [127:0] acc_q;
	logic [63:0] quo_q;
	logic [64:0] rem_q;
	logic [31:0] bmag_q;
	logic neg_q;
	logic [6:0] step_q;
	logic signed [67:0] ar_q [3];
	logic [2:0] ai_q;
	logic signed [31:0] y_q;
	logic hit_q;
	logic out_hit_q;
	logic signed [31:0] out_y_q;
	logic [8:0] out_pos_q;

	logic signed [33:0] ma, mb;
	logic signed [67:0] prod;
	logic signed [32:0] qx_e, qz_e;
	logic [64:0] trial;
	logic signed [65:0] yv;
	logic signed [67:0] t_hi, t_lo;
	logic in_pos, in_neg;
	logic [31:0] bmag_in;
	logic accept;

	function automatic int DivBit(input logic [6:0] s);
		DivBit = 63 - int'(s);
	endfunction

	assign accept = s_axis_tvalid && s_axis_tready;
	assign prod = ma * mb;
	assign qx_e = {qx_q[31], qx_q};
	assign qz_e = {qz_q[31], qz_q};
	assign bmag_in = s_axis_tdata[63] ? 32'(-s_axis_tdata[63:32]) : s_axis_tdata[63:32];
	assign trial = {rem_q[63:0], acc_q[7'(DivBit(step_q))]};

	// Shared multiplier operands: numerator terms, then two products per area.
	always_comb begin
		ma = '0;
		mb = '0;
		case (state_q)
			artfh_pkg::ST_NUM0: begin
				ma = 34'(signed'(tri_q.plane_a));
				mb = 34'(qx_q);
			end
			artfh_pkg::ST_NUM1: begin
				ma = 34'(signed'(tri_q.plane_c));
				mb = 34'(qz_q);
			end
			artfh_pkg::ST_NUM2: begin
				ma = 34'(signed'(tri_q.plane_d));
				mb = 34'sd65536;
			end
			artfh_pkg::ST_AREA: begin
				case (ai_q)
					3'd0: begin
						ma = 34'(signed'(tri_q.vert1_z)) - 34'(qz_e);
						mb = 34'(signed'(tri_q.vert2_x)) - 34'(qx_e);
					end
					3'd1: begin
						ma = 34'(signed'(tri_q.vert2_z)) - 34'(qz_e);
						mb = 34'(signed'(tri_q.vert1_x)) - 34'(qx_e);
					end
					3'd2: begin
						ma = 34'(qz_e) - 34'(signed'(tri_q.vert0_z));
						mb = 34'(signed'(tri_q.vert2_x)) - 34'(signed'(tri_q.vert0_x));
					end
					3'd3: begin
						ma = 34'(signed'(tri_q.vert2_z)) - 34'(signed'(tri_q.vert0_z));
						mb = 34'(qx_e) - 34'(signed'(tri_q.vert0_x));
					end
					3'd4: begin
						ma = 34'(signed'(tri_q.vert1_z)) - 34'(signed'(tri_q.vert0_z));
						mb = 34'(qx_e) - 34'(signed'(tri_q.vert0_x));
					end
					default: begin
						ma = 34'(qz_e) - 34'(signed'(tri_q.vert0_z));
						mb = 34'(signed'(tri_q.vert1_x)) - 34'(signed'(tri_q.vert0_x));
					end
				endcase
			end
			default: begin
				ma = '0;
				mb = '0;
			end
		endcase
	end

	always_comb begin
		yv = neg_q ? -$signed({2'b00, quo_q}) : $signed({2'b00, quo_q});
		t_hi = 68'(signed'({1'b0, atol_q, 16'h0000}));
		t_lo = -t_hi;
		in_pos = $signed(tri_q.normal_y) > -$signed({1'b0, atol_q});
		in_neg = $signed(tri_q.normal_y) < $signed({1'b0, atol_q});
		for (int i = 0; i < 3; i++) begin
			if (ar_q[i] < t_lo) in_pos = 1'b0;
			if (ar_q[i] > t_hi) in_neg = 1'b0;
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			artfh_pkg::ST_IDLE:
				if (accept) begin
					if (found_q || bmag_in <= 32'(ptol_q)) state_nxt = artfh_pkg::ST_DECIDE;
					else state_nxt = artfh_pkg::ST_NUM0;
				end
			artfh_pkg::ST_NUM0: state_nxt = artfh_pkg::ST_NUM1;
			artfh_pkg::ST_NUM1: state_nxt = artfh_pkg::ST_NUM2;
			artfh_pkg::ST_NUM2: state_nxt = artfh_pkg::ST_DIV;
			artfh_pkg::ST_DIV:
				if (step_q == 7'(artfh_pkg::DivSteps - 1)) state_nxt = artfh_pkg::ST_RANGE;
			artfh_pkg::ST_RANGE:
				if (yv < 66'(ylo_q) || yv > 66'(yhi_q)) state_nxt = artfh_pkg::ST_DECIDE;
				else state_nxt = artfh_pkg::ST_AREA;
			artfh_pkg::ST_AREA:
				if (ai_q == 3'd6) state_nxt = artfh_pkg::ST_DECIDE;
			artfh_pkg::ST_DECIDE:
				if ((!found_q && hit_q && (in_pos || in_neg)) || (last_q && !found_q))
					state_nxt = artfh_pkg::ST_OUT;
				else state_nxt = artfh_pkg::ST_IDLE;
			artfh_pkg::ST_OUT:
				if (m_axis_tready) state_nxt = artfh_pkg::ST_IDLE;
			default: state_nxt = artfh_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		s_axis_tready = (state_q == artfh_pkg::ST_IDLE);
		m_axis_tvalid = (state_q == artfh_pkg::ST_OUT);
		m_axis_tdata = {6'd0, out_pos_q, out_y_q, out_hit_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qx_q <= '0;
			qz_q <= '0;
			ylo_q <= '0;
			yhi_q <= '0;
			ptol_q <= '0;
			atol_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				artfh_pkg::REG_QUERY_X: qx_q <= cfg_data;
				artfh_pkg::REG_QUERY_Z: qz_q <= cfg_data;
				artfh_pkg::REG_SEG_Y_LOW: ylo_q <= cfg_data;
				artfh_pkg::REG_SEG_Y_HIGH: yhi_q <= cfg_data;
				artfh_pkg::REG_PAR_TOL: ptol_q <= cfg_data[15:0];
				artfh_pkg::REG_AREA_TOL: atol_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= artfh_pkg::ST_IDLE;
			found_q <= 1'b0;
			count_q <= '0;
			step_q <= '0;
			ai_q <= '0;
			hit_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			case (state_q)
				artfh_pkg::ST_IDLE: begin
					hit_q <= 1'b0;
					step_q <= '0;
					ai_q <= '0;
				end
				artfh_pkg::ST_DIV: step_q <= step_q + 7'd1;
				artfh_pkg::ST_AREA: begin
					ai_q <= ai_q + 3'd1;
					if (ai_q == 3'd6) hit_q <= 1'b1;
				end
				artfh_pkg::ST_DECIDE: begin
					hit_q <= hit_q && (in_pos || in_neg);
					if (last_q) begin
						found_q <= 1'b0;
						count_q <= '0;
					end else begin
						if (!found_q && hit_q && (in_pos || in_neg)) found_q <= 1'b1;
						if (count_q != '1) count_q <= count_q + 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			artfh_pkg::ST_IDLE:
				if (accept) begin
					tri_q <= s_axis_tdata;
					last_q <= s_axis_tlast;
					bmag_q <= bmag_in;
					neg_q <= s_axis_tdata[63];
					acc_q <= '0;
				end
			artfh_pkg::ST_NUM0: acc_q <= acc_q - 128'(prod);
			artfh_pkg::ST_NUM1: acc_q <= acc_q - 128'(prod);
			artfh_pkg::ST_NUM2: begin
				if ((acc_q - 128'(prod)) < 0) begin
					acc_q <= -(acc_q - 128'(prod));
					neg_q <= !neg_q;
				end else begin
					acc_q <= acc_q - 128'(prod);
				end
				rem_q <= '0;
				quo_q <= '0;
			end
			artfh_pkg::ST_DIV: begin
				if (trial >= {33'd0, bmag_q}) begin
					rem_q <= trial - {33'd0, bmag_q};
					quo_q <= {quo_q[62:0], 1'b1};
				end else begin
					rem_q <= trial;
					quo_q <= {quo_q[62:0], 1'b0};
				end
			end
			artfh_pkg::ST_RANGE: y_q <= yv[31:0];
			artfh_pkg::ST_AREA:
				case (ai_q)
					3'd0, 3'd2, 3'd4: ar_q[ai_q[2:1]] <= prod;
					3'd1, 3'd3, 3'd5: ar_q[ai_q[2:1]] <= ar_q[ai_q[2:1]] - prod;
					default: ;
				endcase
			artfh_pkg::ST_DECIDE:
				if (!found_q && hit_q && (in_pos || in_neg)) begin
					out_hit_q <= 1'b1;
					out_y_q <= y_q;
					out_pos_q <= 9'(count_q);
				end else begin
					out_hit_q <= 1'b0;
					out_y_q <= '0;
					out_pos_q <= '1;
				end
			default: ;
		endcase
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("result beat dropped while stalled");
	a_no_in_busy: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !s_axis_tready)
		else $error("input taken while result pending");
	a_miss_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[41:33] == 9'h1ff)
		else $error("miss beat without position -1");
endmodule

FILE: tb/axis_ray_triangle_first_hit_checker.sv
// Checker for the ray/triangle first-hit block. It watches the write port and both
// stream channels, predicts each list's result and compares it beat by beat.
// Depends on artfh_pkg.
module axis_ray_triangle_first_hit_checker (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [2:0]   cfg_index,
	input  logic [31:0]  cfg_data,
	input  logic         s_axis_tvalid,
	input  logic         s_axis_tready,
	input  logic [351:0] s_axis_tdata,
	input  logic         s_axis_tlast,
	input  logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	input  logic [47:0]  m_axis_tdata,
	output int           errors,
	output int           pending
);
	typedef struct {
		logic        hit;
		logic [31:0] y;
		logic [8:0]  pos;
	} crossing_t;

	crossing_t crossings_due[$];
	logic [31:0] line_x, line_z, y_low, y_high;
	logic [15:0] par_tol, area_tol;
	logic found;
	int list_pos;

	task automatic report(input string msg);
		$display("mismatch: %s", msg);
		errors++;
	endtask

	function automatic logic signed [127:0] twice_area(input logic signed [127:0] z0, x0,
		z1, x1, z2, x2);
		return (z1 - z0) * (x2 - x0) - (z2 - z0) * (x1 - x0);
	endfunction

	function automatic logic crosses(input logic [351:0] t, output logic [31:0] y);
		logic signed [127:0] a, b, c, d, qx, qz, num, nmag, bmag, q, yv, tol, tarea, ny;
		logic signed [127:0] ar [3];
		logic pos_ok, neg_ok;
		a = $signed(t[31:0]);
		b = $signed(t[63:32]);
		c = $signed(t[95:64]);
		d = $signed(t[127:96]);
		qx = $signed(line_x);
		qz = $signed(line_z);
		y = '0;
		bmag = (b < 0) ? -b : b;
		if (bmag <= $signed({112'd0, par_tol}))
			return 1'b0;
		num = -(a * qx) - c * qz - d * 128'sd65536;
		nmag = (num < 0) ? -num : num;
		q = nmag / bmag;
		if (q > 128'sh1_0000_0000)
			q = 128'sh1_0000_0000;
		yv = ((num < 0) != (b < 0)) ? -q : q;
		if (yv < $signed(y_low) || yv > $signed(y_high))
			return 1'b0;
		ar[0] = twice_area(qz, qx, $signed(t[223:192]), $signed(t[255:224]),
			$signed(t[287:256]), $signed(t[319:288]));
		ar[1] = twice_area($signed(t[159:128]), $signed(t[191:160]), qz, qx,
			$signed(t[287:256]), $signed(t[319:288]));
		ar[2] = twice_area($signed(t[159:128]), $signed(t[191:160]),
			$signed(t[223:192]), $signed(t[255:224]), qz, qx);
		tol = $signed({112'd0, area_tol});
		tarea = tol * 128'sd65536;
		ny = $signed(t[351:320]);
		pos_ok = ny > -tol;
		neg_ok = ny < tol;
		for (int i = 0; i < 3; i++) begin
			if (ar[i] < -tarea)
				pos_ok = 1'b0;
			if (ar[i] > tarea)
				neg_ok = 1'b0;
		end
		if (!pos_ok && !neg_ok)
			return 1'b0;
		y = yv[31:0];
		return 1'b1;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		crossing_t e, got;
		logic [31:0] y;
		if (!arst_n) begin
			line_x = '0;
			line_z = '0;
			y_low = '0;
			y_high = '0;
			par_tol = '0;
			area_tol = '0;
			found = 1'b0;
			list_pos = 0;
			errors = 0;
			pending = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					artfh_pkg::REG_QUERY_X: line_x = cfg_data;
					artfh_pkg::REG_QUERY_Z: line_z = cfg_data;
					artfh_pkg::REG_SEG_Y_LOW: y_low = cfg_data;
					artfh_pkg::REG_SEG_Y_HIGH: y_high = cfg_data;
					artfh_pkg::REG_PAR_TOL: par_tol = cfg_data[15:0];
					artfh_pkg::REG_AREA_TOL: area_tol = cfg_data[15:0];
					default: ;
				endcase
			end
			if (m_axis_tvalid && m_axis_tready) begin
				got.hit = m_axis_tdata[0];
				got.y = m_axis_tdata[32:1];
				got.pos = m_axis_tdata[41:33];
				if (crossings_due.size() == 0) begin
					report("result beat with no result expected");
				end else begin
					e = crossings_due.pop_front();
					if (got.hit !== e.hit)
						report($sformatf("hit %b, expected %b", got.hit, e.hit));
					if (got.y !== e.y)
						report($sformatf("intersect_y %h, expected %h", got.y, e.y));
					if (got.pos !== e.pos)
						report($sformatf("hit_position %h, expected %h", got.pos, e.pos));
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				if (!found && crosses(s_axis_tdata, y)) begin
					found = 1'b1;
					e.hit = 1'b1;
					e.y = y;
					e.pos = list_pos[8:0];
					crossings_due.push_back(e);
				end else if (s_axis_tlast && !found) begin
					e.hit = 1'b0;
					e.y = '0;
					e.pos = '1;
					crossings_due.push_back(e);
				end
				if (s_axis_tlast) begin
					found = 1'b0;
					list_pos = 0;
				end else if (list_pos < int'(artfh_pkg::MaxCandidates) - 1) begin
					list_pos++;
				end
			end
			pending = crossings_due.size();
		end
	end
endmodule

FILE: tb/axis_ray_triangle_first_hit_top_tb.sv
// Testbench top for the ray/triangle first-hit block: clock, reset, register
// writes and triangle lists, with the verdict. Depends on artfh_pkg, the block
// and axis_ray_triangle_first_hit_checker.
module axis_ray_triangle_first_hit_top_tb;
	localparam logic [2:0] RegUnused = 3'd6;
	localparam int CycleLimit = 600000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [2:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [351:0] s_axis_tdata = '0;
	logic s_axis_tlast = 1'b0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [47:0] m_axis_tdata;
	int errors, pending;
	int send_idle, recv_idle, cycles;
	logic [31:0] tri_f [11];
	int line_x, line_z;

	axis_ray_triangle_first_hit_top dut (.*);
	axis_ray_triangle_first_hit_checker chk (.*);

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	always @(negedge clk)
		m_axis_tready <= ($urandom_range(99) >= recv_idle);

	always @(posedge clk) begin
		cycles++;
		if (cycles > CycleLimit) begin
			$display("FAIL");
			$finish;
		end
	end

	task automatic write_reg(input logic [2:0] idx, input logic [31:0] v);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = v;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic drain();
		s_axis_tvalid = 1'b0;
		wait (pending == 0);
		repeat (120) @(negedge clk);
	endtask

	task automatic setup(input int qx, qz, lo, hi, input logic [15:0] pt, at);
		drain();
		line_x = qx;
		line_z = qz;
		write_reg(artfh_pkg::REG_QUERY_X, qx);
		write_reg(artfh_pkg::REG_QUERY_Z, qz);
		write_reg(artfh_pkg::REG_SEG_Y_LOW, lo);
		write_reg(artfh_pkg::REG_SEG_Y_HIGH, hi);
		write_reg(artfh_pkg::REG_PAR_TOL, {16'($urandom_range(65535)), pt});
		write_reg(artfh_pkg::REG_AREA_TOL, {16'($urandom_range(65535)), at});
	endtask

	task automatic send(input logic last);
		while ($urandom_range(99) < send_idle) begin
			s_axis_tvalid = 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid = 1'b1;
		for (int i = 0; i < 11; i++)
			s_axis_tdata[i*32 +: 32] = tri_f[i];
		s_axis_tlast = last;
		do
			@(posedge clk);
		while (!s_axis_tready);
		@(negedge clk);
	endtask

	task automatic fill_all(input logic [31:0] v);
		for (int i = 0; i < 11; i++)
			tri_f[i] = v;
	endtask

	task automatic fill_random();
		for (int i = 0; i < 11; i++)
			tri_f[i] = $urandom;
	endtask

	// A plane with a solid y slope and a triangle placed around the query line,
	// sometimes shifted off it, with random winding and normal sign.
	task automatic fill_facing();
		int r, cz, sgn;
		r = $urandom_range(1 << 20, 16);
		sgn = $urandom_range(1) ? 1 : -1;
		cz = line_z + (($urandom_range(3) == 0) ? 3 * r * sgn : 0);
		tri_f[0] = $urandom_range(131072) - 65536;
		tri_f[1] = $urandom_range(4, 1) * 65536 * sgn;
		tri_f[2] = $urandom_range(131072) - 65536;
		tri_f[3] = $urandom_range(1 << 20) - (1 << 19);
		tri_f[4] = cz - r;
		tri_f[5] = line_x - r;
		if ($urandom_range(1)) begin
			tri_f[6] = cz + r;
			tri_f[7] = line_x - r;
			tri_f[8] = cz;
			tri_f[9] = line_x + r;
		end else begin
			tri_f[6] = cz;
			tri_f[7] = line_x + r;
			tri_f[8] = cz + r;
			tri_f[9] = line_x - r;
		end
		tri_f[10] = ($urandom_range(1) ? 1 : -1) * $urandom_range(65536, 1);
	endtask

	task automatic random_lists(input int n);
		int len;
		while (n > 0) begin
			len = $urandom_range(8, 1);
			for (int k = 0; k < len; k++) begin
				if ($urandom_range(9) < 7)
					fill_facing();
				else
					fill_random();
				send(k == len - 1);
			end
			n -= len;
		end
	endtask

	initial begin
		send_idle = 0;
		recv_idle = 0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Registers still at their reset values.
		fill_all('0);
		send(1'b1);
		fill_all(32'h7fff_ffff);
		send(1'b1);
		fill_all(32'h8000_0000);
		send(1'b1);

		send_idle = 36;
		recv_idle = 66;
		setup(32'h0001_8000, -32'sh0002_4000, 32'h8000_0000, 32'h7fff_ffff, 16'd300, 16'd40);
		write_reg(RegUnused, 32'hffff_ffff);
		fill_facing();
		tri_f[1] = 32'd300;
		send(1'b0);
		fill_facing();
		send(1'b1);
		fill_facing();
		send(1'b0);
		fill_random();
		send(1'b0);
		fill_facing();
		send(1'b1);
		fill_random();
		send(1'b0);
		fill_random();
		send(1'b1);
		drain();
		random_lists(50);

		send_idle = 66;
		recv_idle = 36;
		setup(32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 16'hffff, 16'hffff);
		random_lists(40);

		send_idle = 0;
		recv_idle = 0;
		setup($urandom_range(1 << 22) - (1 << 21), $urandom_range(1 << 22) - (1 << 21),
			32'd5, -32'sd5, 16'd0, 16'd0);
		random_lists(40);

		send_idle = 36;
		recv_idle = 66;
		setup($urandom_range(1 << 22) - (1 << 21), $urandom_range(1 << 22) - (1 << 21),
			-32'sh0100_0000, 32'sh0100_0000, 16'd0, 16'd0);
		random_lists(60);

		// One list longer than the position counter can count.
		send_idle = 0;
		recv_idle = 0;
		setup(32'h0000_4000, 32'h0000_c000, 32'h8000_0000, 32'h7fff_ffff, 16'd0, 16'd0);
		for (int k = 0; k < 262; k++) begin
			fill_random();
			tri_f[1] = 32'd0;
			if (k == 261)
				fill_facing();
			send(k == 261);
		end

		drain();
		if (errors == 0 && pending == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end
endmodule
